// File: rtl/fspa_pkg.sv
// shared constants, codes and types of the fixed slot pool allocator
package fspa_pkg;

  localparam int unsigned SLOTS         = 1024;
  localparam int unsigned OBJECT_BYTES  = 64;
  localparam int unsigned TABLE_ENTRIES = 65536;
  localparam int unsigned POINTER_BYTES = 4;

  localparam int unsigned SLOT_W    = 11;
  localparam int unsigned IDX_W     = $clog2(SLOTS);
  localparam int unsigned OBJ_SHIFT = $clog2(OBJECT_BYTES);
  localparam int unsigned WORD_W    = SLOT_W + 1;

  localparam int unsigned IN_DATA_W  = 112;
  localparam int unsigned OUT_DATA_W = 48;
  localparam int unsigned FUNC_W     = 3;

  localparam logic [31:0] POOL_SPAN    = 32'(SLOTS * OBJECT_BYTES);
  localparam logic [31:0] OBJ_MASK     = 32'(OBJECT_BYTES - 1);
  localparam logic [31:0] TABLE_STRIDE = 32'(TABLE_ENTRIES * POINTER_BYTES);
  localparam logic [32:0] ENTRY_LIMIT  = 33'(TABLE_ENTRIES);
  localparam logic [SLOT_W-1:0] SLOT_NONE = SLOT_W'(SLOTS);

  localparam logic CFG_POOL_BASE  = 1'b0;
  localparam logic CFG_TABLE_BASE = 1'b1;

  typedef enum logic [FUNC_W-1:0] {
    FN_CLEAR   = 3'd0,
    FN_TAKE    = 3'd1,
    FN_GIVE    = 3'd2,
    FN_LOOKUP  = 3'd3,
    FN_RELEASE = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CLEAR
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic sweep;
  } dp_cmd_t;

  typedef struct packed {
    logic in_clear;
    logic out_free;
    logic sweep_last;
  } dp_status_t;

endpackage

// File: rtl/fspa_ram.sv
// generic single-port-write ram with registered read
module fspa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/fspa_ctrl.sv
// controller state machine of the fixed slot pool allocator
module fspa_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  fspa_pkg::dp_status_t status,
  output fspa_pkg::dp_cmd_t    cmd
);

  fspa_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fspa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      fspa_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = status.in_clear ? fspa_pkg::ST_CLEAR : fspa_pkg::ST_EXEC;
        end
      end
      fspa_pkg::ST_EXEC: begin
        if (status.out_free) begin
          state_next = fspa_pkg::ST_IDLE;
        end
      end
      fspa_pkg::ST_CLEAR: begin
        if (status.sweep_last) begin
          state_next = fspa_pkg::ST_EXEC;
        end
      end
      default: state_next = fspa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    cmd       = '0;
    case (state)
      fspa_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      fspa_pkg::ST_EXEC: begin
        cmd.exec = status.out_free;
      end
      fspa_pkg::ST_CLEAR: begin
        cmd.sweep = 1'b1;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

// File: rtl/fspa_dp.sv
// datapath: config registers, address mapping, free list ram, head and result register
module fspa_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_index,
  input  logic [31:0]                         cfg_data,
  input  logic [fspa_pkg::IN_DATA_W-1:0]      s_tdata,
  input  logic [fspa_pkg::FUNC_W-1:0]         s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [fspa_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic                                m_tuser,
  input  fspa_pkg::dp_cmd_t                   cmd,
  output fspa_pkg::dp_status_t                status
);

  localparam int unsigned SW = fspa_pkg::SLOT_W;
  localparam int unsigned IW = fspa_pkg::IDX_W;
  localparam int unsigned WW = fspa_pkg::WORD_W;
  localparam int unsigned PAD_W = fspa_pkg::OUT_DATA_W - 32 - SW;

  logic [31:0] pool_base, table_base;

  logic [15:0] in_req;
  logic [31:0] in_addr, in_count, in_tptr;
  logic [31:0] offset;
  logic [SW-1:0] mapped, slot_sel;

  logic [fspa_pkg::FUNC_W-1:0] func_q;
  logic req_ok_q, count_ok_q;
  logic [31:0] tptr_q;
  logic [SW-1:0] slot_q;

  logic [SW-1:0] head;
  logic pool_ready;
  logic [IW-1:0] sweep_cnt;

  logic [WW-1:0] ram_q, ram_wdata, wdata_c;
  logic [IW-1:0] ram_waddr;
  logic ram_we;

  logic slot_valid, active;
  logic [SW-1:0] link;
  logic [31:0] slot_addr, tbl_addr;
  logic ok_c, wr_c, head_we;
  logic [31:0] raddr_c;
  logic [SW-1:0] slot_c, head_next;

  logic ok_q;
  logic [31:0] raddr_q;
  logic [SW-1:0] slot_out_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base  <= '0;
      table_base <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == fspa_pkg::CFG_POOL_BASE) begin
        pool_base <= cfg_data;
      end else begin
        table_base <= cfg_data;
      end
    end
  end

  assign in_req   = s_tdata[15:0];
  assign in_addr  = s_tdata[47:16];
  assign in_count = s_tdata[79:48];
  assign in_tptr  = s_tdata[111:80];

  // object address to slot: inside the pool and on an object boundary
  assign offset = in_addr - pool_base;
  assign mapped = (in_addr >= pool_base && offset < fspa_pkg::POOL_SPAN &&
                   (offset & fspa_pkg::OBJ_MASK) == 32'd0)
                  ? SW'(offset >> fspa_pkg::OBJ_SHIFT) : fspa_pkg::SLOT_NONE;
  assign slot_sel = (s_tuser == fspa_pkg::FN_TAKE) ? head : mapped;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q     <= s_tuser;
      req_ok_q   <= (in_req == 16'(fspa_pkg::OBJECT_BYTES));
      count_ok_q <= ({1'b0, in_count} < fspa_pkg::ENTRY_LIMIT);
      tptr_q     <= in_tptr;
      slot_q     <= slot_sel;
    end
  end

  // word layout: active bit on top, next-free link below
  fspa_ram #(
    .WIDTH (fspa_pkg::WORD_W),
    .DEPTH (fspa_pkg::SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.load),
    .raddr (slot_sel[IW-1:0]),
    .rdata (ram_q)
  );

  // before the first clear every slot reads as inactive
  assign slot_valid = (slot_q < fspa_pkg::SLOT_NONE);
  assign active     = pool_ready & ram_q[WW-1];
  assign link       = ram_q[SW-1:0];
  assign slot_addr  = pool_base + (32'(slot_q) << fspa_pkg::OBJ_SHIFT);
  assign tbl_addr   = table_base + 32'(slot_q) * fspa_pkg::TABLE_STRIDE;

  always_comb begin
    ok_c      = 1'b0;
    raddr_c   = '0;
    slot_c    = fspa_pkg::SLOT_NONE;
    wr_c      = 1'b0;
    wdata_c   = '0;
    head_we   = 1'b0;
    head_next = head;
    case (func_q)
      fspa_pkg::FN_CLEAR: begin
        ok_c      = 1'b1;
        head_we   = 1'b1;
        head_next = '0;
      end
      fspa_pkg::FN_TAKE: begin
        if (req_ok_q && slot_valid) begin
          ok_c      = 1'b1;
          raddr_c   = slot_addr;
          slot_c    = slot_q;
          wr_c      = 1'b1;
          wdata_c   = {1'b1, link};
          head_we   = 1'b1;
          head_next = link;
        end
      end
      fspa_pkg::FN_GIVE: begin
        slot_c = slot_q;
        if (slot_valid && active) begin
          ok_c      = 1'b1;
          wr_c      = 1'b1;
          wdata_c   = {1'b0, head};
          head_we   = 1'b1;
          head_next = slot_q;
        end
      end
      fspa_pkg::FN_LOOKUP: begin
        slot_c = slot_q;
        if (slot_valid && active && count_ok_q) begin
          ok_c    = 1'b1;
          raddr_c = tbl_addr;
        end
      end
      fspa_pkg::FN_RELEASE: begin
        slot_c = slot_q;
        ok_c   = slot_valid && active && (tptr_q == tbl_addr);
      end
      default: begin
        ok_c = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (cmd.sweep) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_cnt;
      ram_wdata = {1'b0, SW'(sweep_cnt) + SW'(1)};
    end else begin
      ram_we    = cmd.exec & wr_c;
      ram_waddr = slot_q[IW-1:0];
      ram_wdata = wdata_c;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sweep_cnt <= '0;
    end else if (cmd.sweep) begin
      sweep_cnt <= sweep_cnt + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= fspa_pkg::SLOT_NONE;
      pool_ready <= 1'b0;
    end else if (cmd.exec) begin
      if (head_we) begin
        head <= head_next;
      end
      if (func_q == fspa_pkg::FN_CLEAR) begin
        pool_ready <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.exec) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      ok_q       <= ok_c;
      raddr_q    <= raddr_c;
      slot_out_q <= slot_c;
    end
  end

  assign m_tdata = {{PAD_W{1'b0}}, slot_out_q, raddr_q};
  assign m_tuser = ok_q;

  assign status.in_clear   = (s_tuser == fspa_pkg::FN_CLEAR);
  assign status.out_free   = ~m_tvalid | m_tready;
  assign status.sweep_last = (sweep_cnt == IW'(fspa_pkg::SLOTS - 1));

endmodule

// File: rtl/fixed_slot_pool_allocator_core.sv
// top level of the fixed slot pool allocator
// Pool of 1024 objects of 64 bytes handed out from a LIFO free list. Each request
// is one of clear, take, give back, table lookup or release check and gives one
// result. A request other than clear first reads the slot's word (next-free link
// and active bit) from the single-port-write ram with registered read, then
// updates it, the list head and the result register. Clear sweeps the ram one
// slot a cycle. No pass runs after reset: the pool is empty and every slot
// inactive until the first clear. A result waiting at the output does not stop
// the next request from being accepted; it only holds back that request's update
// until the output register frees.
module fixed_slot_pool_allocator_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_index,
  input  logic [31:0]   cfg_data,
  input  logic          s_tvalid,
  output logic          s_tready,
  // request_bytes[15:0], address[47:16], entry_count[79:48], table_pointer[111:80]
  input  logic [111:0]  s_tdata,
  // func[2:0]
  input  logic [2:0]    s_tuser,
  output logic          m_tvalid,
  input  logic          m_tready,
  // result_address[31:0], slot_index[42:32], zero fill[47:43]
  output logic [47:0]   m_tdata,
  // ok[0]
  output logic          m_tuser
);

  fspa_pkg::dp_cmd_t    cmd;
  fspa_pkg::dp_status_t status;

  fspa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  fspa_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// File: rtl/fspa_checker.sv
// port-level checks of the fixed slot pool allocator, bound to the top level
module fspa_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic        m_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // one request in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while previous one still in work");

  // a failed request returns address zero
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[31:0] == 32'd0)
    else $error("failed result carries an address");

  // slot index never beyond the none code, a nonzero address names a real slot
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[42:32] <= 11'd1024 && m_tdata[47:43] == 5'd0 &&
                 (m_tdata[31:0] == 32'd0 || m_tdata[42:32] != 11'd1024))
    else $error("slot index out of range");

endmodule

bind fixed_slot_pool_allocator_core fspa_checker u_fspa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// File: tb/testbench.sv
// self-checking testbench for the fixed slot pool allocator core
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned REPORT_MAX  = 10;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic          cfg_index = fspa_pkg::CFG_POOL_BASE;
  logic [31:0]   cfg_data = '0;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [111:0]  s_tdata = '0;
  logic [2:0]    s_tuser = '0;
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [47:0]   m_tdata;
  logic          m_tuser;

  int unsigned tx_idle_pct = 25;
  int unsigned rx_idle_pct = 25;
  int unsigned stall_cycles = 0;

  fixed_slot_pool_allocator_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always #10 clk = ~clk;

  // mirror of the pool state and the queue of results it predicts
  class pool_tracker;
    typedef struct packed {
      logic                        ok;
      logic [31:0]                 addr;
      logic [fspa_pkg::SLOT_W-1:0] slot;
    } pool_result_t;

    logic [31:0]                 pool_base;
    logic [31:0]                 table_base;
    logic [fspa_pkg::SLOT_W-1:0] head;
    logic [fspa_pkg::SLOT_W-1:0] link [fspa_pkg::SLOTS];
    bit                          active [fspa_pkg::SLOTS];
    pool_result_t                pending_results[$];
    int unsigned                 errors;

    function new();
      pool_base  = '0;
      table_base = '0;
      head       = fspa_pkg::SLOT_NONE;
      errors     = 0;
      foreach (active[i]) begin
        active[i] = 1'b0;
        link[i]   = '0;
      end
    endfunction

    function void set_reg(logic idx, logic [31:0] value);
      if (idx == fspa_pkg::CFG_POOL_BASE) pool_base = value;
      else table_base = value;
    endfunction

    function logic [31:0] object_address(int unsigned s);
      return pool_base + 32'(s * fspa_pkg::OBJECT_BYTES);
    endfunction

    function logic [31:0] table_address(int unsigned s);
      return table_base + 32'(s) * fspa_pkg::TABLE_STRIDE;
    endfunction

    function logic [fspa_pkg::SLOT_W-1:0] slot_of(logic [31:0] a);
      logic [31:0] off;
      if (a < pool_base) return fspa_pkg::SLOT_NONE;
      off = a - pool_base;
      if (off >= fspa_pkg::POOL_SPAN || (off & fspa_pkg::OBJ_MASK) != 32'd0)
        return fspa_pkg::SLOT_NONE;
      return fspa_pkg::SLOT_W'(off >> fspa_pkg::OBJ_SHIFT);
    endfunction

    function void flag(string what);
      errors++;
      if (errors <= REPORT_MAX) $display("[%0t] %s", $realtime, what);
    endfunction

    function void note_request(logic [2:0] fn, logic [15:0] req, logic [31:0] a,
                               logic [31:0] cnt, logic [31:0] tptr);
      pool_result_t r;
      logic [fspa_pkg::SLOT_W-1:0] s;
      r.ok   = 1'b0;
      r.addr = '0;
      r.slot = fspa_pkg::SLOT_NONE;
      case (fn)
        fspa_pkg::FN_CLEAR: begin
          for (int i = 0; i < fspa_pkg::SLOTS; i++) begin
            active[i] = 1'b0;
            link[i]   = fspa_pkg::SLOT_W'(i + 1);
          end
          head = '0;
          r.ok = 1'b1;
        end
        fspa_pkg::FN_TAKE: begin
          if (req == 16'(fspa_pkg::OBJECT_BYTES) && head < fspa_pkg::SLOT_NONE) begin
            s         = head;
            head      = link[s];
            active[s] = 1'b1;
            r.ok      = 1'b1;
            r.addr    = object_address(32'(s));
            r.slot    = s;
          end
        end
        fspa_pkg::FN_GIVE: begin
          s      = slot_of(a);
          r.slot = s;
          if (s < fspa_pkg::SLOT_NONE && active[s]) begin
            active[s] = 1'b0;
            link[s]   = head;
            head      = s;
            r.ok      = 1'b1;
          end
        end
        fspa_pkg::FN_LOOKUP: begin
          s      = slot_of(a);
          r.slot = s;
          if (s < fspa_pkg::SLOT_NONE && active[s] && cnt < fspa_pkg::TABLE_ENTRIES) begin
            r.ok   = 1'b1;
            r.addr = table_address(32'(s));
          end
        end
        fspa_pkg::FN_RELEASE: begin
          s      = slot_of(a);
          r.slot = s;
          if (s < fspa_pkg::SLOT_NONE && active[s] && tptr == table_address(32'(s)))
            r.ok = 1'b1;
        end
        default: ;
      endcase
      pending_results.push_back(r);
    endfunction

    function void check_result(logic ok, logic [31:0] a, logic [fspa_pkg::SLOT_W-1:0] s);
      pool_result_t want;
      if (pending_results.size() == 0) begin
        flag($sformatf("result with nothing pending: ok=%0b addr=%h slot=%0d", ok, a, s));
        return;
      end
      want = pending_results.pop_front();
      if (want.ok !== ok || want.addr !== a || want.slot !== s)
        flag($sformatf("mismatch: ok %0b/%0b addr %h/%h slot %0d/%0d (expected/actual)",
                       want.ok, ok, want.addr, a, want.slot, s));
    endfunction
  endclass

  pool_tracker tracker = new();

  // result side: check accepted results, stall at random
  always @(posedge clk) begin
    if (m_tvalid && m_tready) tracker.check_result(m_tuser, m_tdata[31:0], m_tdata[42:32]);
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("fixed_slot_pool_allocator_core regression: fail");
      $finish;
    end
  end

  task automatic send_request(logic [2:0] fn, logic [15:0] req, logic [31:0] a,
                              logic [31:0] cnt, logic [31:0] tptr);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= fn;
    s_tdata  <= {tptr, cnt, a, req};
    do @(posedge clk); while (!s_tready);
    tracker.note_request(fn, req, a, cnt, tptr);
  endtask

  task automatic wait_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.pending_results.size() != 0);
  endtask

  task automatic set_regs(logic [31:0] pool, logic [31:0] tbl);
    wait_results();
    // let a clear sweep or a held-back update finish before touching the bases
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= fspa_pkg::CFG_POOL_BASE;
    cfg_data  <= pool;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_reg(fspa_pkg::CFG_POOL_BASE, pool);
    cfg_index <= fspa_pkg::CFG_TABLE_BASE;
    cfg_data  <= tbl;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_reg(fspa_pkg::CFG_TABLE_BASE, tbl);
    cfg_valid <= 1'b0;
  endtask

  // mostly addresses of taken slots, the rest any slot's address, off-grid, out of range or random
  function automatic logic [31:0] pick_address();
    int unsigned p, s, start;
    p     = $urandom_range(99);
    start = $urandom_range(fspa_pkg::SLOTS - 1);
    if (p < 70) begin
      for (int k = 0; k < fspa_pkg::SLOTS; k++) begin
        s = (start + k) % fspa_pkg::SLOTS;
        if (tracker.active[s]) return tracker.object_address(s);
      end
      return tracker.object_address(start);
    end
    if (p < 78) return tracker.object_address(start);
    if (p < 84)
      return tracker.object_address(start) + $urandom_range(1, fspa_pkg::OBJECT_BYTES - 1);
    if (p < 89) return tracker.pool_base - $urandom_range(1, 4096);
    if (p < 94) return tracker.pool_base + fspa_pkg::POOL_SPAN + $urandom_range(0, 4095);
    return $urandom;
  endfunction

  task automatic mixed_request();
    logic [2:0]  fn;
    logic [31:0] a, cnt, tptr;
    logic [15:0] req;
    int unsigned p;
    p = $urandom_range(99);
    if (p < 2) fn = fspa_pkg::FN_CLEAR;
    else if (p < 28) fn = fspa_pkg::FN_TAKE;
    else if (p < 52) fn = fspa_pkg::FN_GIVE;
    else if (p < 74) fn = fspa_pkg::FN_LOOKUP;
    else if (p < 96) fn = fspa_pkg::FN_RELEASE;
    else fn = 3'($urandom_range(fspa_pkg::FN_RELEASE + 1, (1 << fspa_pkg::FUNC_W) - 1));
    a   = pick_address();
    req = ($urandom_range(99) < 85) ? 16'(fspa_pkg::OBJECT_BYTES) : 16'($urandom);
    p   = $urandom_range(99);
    if (p < 50) cnt = $urandom_range(fspa_pkg::TABLE_ENTRIES - 1);
    else if (p < 60) cnt = fspa_pkg::TABLE_ENTRIES - 1;
    else if (p < 70) cnt = fspa_pkg::TABLE_ENTRIES;
    else cnt = $urandom;
    tptr = ($urandom_range(99) < 70) ? tracker.table_address(32'(tracker.slot_of(a)))
                                     : $urandom;
    send_request(fn, req, a, cnt, tptr);
  endtask

  initial begin
    logic [31:0] p0, last, span;
    logic [15:0] obj, obj_short;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    obj       = 16'(fspa_pkg::OBJECT_BYTES);
    obj_short = 16'(fspa_pkg::OBJECT_BYTES - 1);
    set_regs(32'h1000_0000, 32'h8000_0000);
    p0   = tracker.object_address(0);
    last = tracker.object_address(fspa_pkg::SLOTS - 1);
    span = fspa_pkg::POOL_SPAN;
    // pool is empty until the first clear
    send_request(fspa_pkg::FN_TAKE, obj, '0, '0, '0);
    send_request(fspa_pkg::FN_GIVE, '1, p0, '1, '1);
    send_request(fspa_pkg::FN_LOOKUP, '0, p0, '0, '0);
    send_request(fspa_pkg::FN_RELEASE, '0, p0, '0, tracker.table_address(0));
    send_request(fspa_pkg::FN_CLEAR, '1, '1, '1, '1);
    send_request(fspa_pkg::FN_TAKE, obj_short, '0, '0, '0);
    send_request(fspa_pkg::FN_TAKE, '1, '0, '0, '0);
    send_request(fspa_pkg::FN_TAKE, obj, '0, '0, '0);
    send_request(fspa_pkg::FN_TAKE, obj, '1, '1, '1);
    send_request(fspa_pkg::FN_LOOKUP, '0, p0 + fspa_pkg::OBJECT_BYTES,
                 fspa_pkg::TABLE_ENTRIES - 1, '0);
    send_request(fspa_pkg::FN_LOOKUP, '0, p0 + fspa_pkg::OBJECT_BYTES,
                 fspa_pkg::TABLE_ENTRIES, '0);
    send_request(fspa_pkg::FN_LOOKUP, '0, p0 + fspa_pkg::OBJECT_BYTES, '1, '0);
    send_request(fspa_pkg::FN_RELEASE, '0, p0 + fspa_pkg::OBJECT_BYTES, '0,
                 tracker.table_address(1));
    send_request(fspa_pkg::FN_RELEASE, '0, p0 + fspa_pkg::OBJECT_BYTES, '0,
                 tracker.table_address(1) + 4);
    send_request(fspa_pkg::FN_GIVE, '0, p0 + fspa_pkg::OBJECT_BYTES + 1, '0, '0);
    send_request(fspa_pkg::FN_GIVE, '0, p0 - fspa_pkg::OBJECT_BYTES, '0, '0);
    send_request(fspa_pkg::FN_GIVE, '0, p0 + span, '0, '0);
    send_request(fspa_pkg::FN_GIVE, '0, last, '0, '0);
    send_request(fspa_pkg::FN_GIVE, '0, p0, '0, '0);
    send_request(fspa_pkg::FN_GIVE, '0, p0, '0, '0);
    send_request(fspa_pkg::FN_TAKE, obj, '0, '0, '0);
    for (int f = fspa_pkg::FN_RELEASE + 1; f < (1 << fspa_pkg::FUNC_W); f++)
      send_request(3'(f), obj, p0, '0, '0);
    send_request(fspa_pkg::FN_CLEAR, '0, '0, '0, '0);

    set_regs('1, '1);
    repeat (80) mixed_request();

    // drain most of the pool with no idling on either side
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_regs('0, '0);
    send_request(fspa_pkg::FN_CLEAR, 16'($urandom), $urandom, $urandom, $urandom);
    for (int n = 0; n < fspa_pkg::SLOTS + 6; n++) begin
      if (n == fspa_pkg::SLOTS / 2) wait_results();
      if ($urandom_range(99) < 95)
        send_request(fspa_pkg::FN_TAKE, obj, $urandom, $urandom, $urandom);
      else
        send_request(fspa_pkg::FN_LOOKUP, 16'($urandom), pick_address(),
                     $urandom_range(fspa_pkg::TABLE_ENTRIES - 1), $urandom);
    end
    tx_idle_pct = 25;
    rx_idle_pct = 25;

    set_regs($urandom, $urandom);
    repeat (80) mixed_request();
    set_regs(32'hFFFF_FFC0, $urandom);
    repeat (80) mixed_request();
    set_regs($urandom & ~fspa_pkg::OBJ_MASK, '0);
    repeat (80) mixed_request();

    wait_results();
    repeat (8) @(posedge clk);
    if (tracker.errors == 0)
      $display("fixed_slot_pool_allocator_core regression: pass");
    else
      $display("fixed_slot_pool_allocator_core regression: fail");
    $finish;
  end

endmodule

// File: files.f
rtl/fspa_pkg.sv
rtl/fspa_ram.sv
rtl/fspa_ctrl.sv
rtl/fspa_dp.sv
rtl/fixed_slot_pool_allocator_core.sv
rtl/fspa_checker.sv
tb/testbench.sv
